// ----- src/chunk_stream_slot_table_macros.svh -----
// Assertion helpers for the chunk stream slot table
`ifndef CHUNK_STREAM_SLOT_TABLE_MACROS_SVH
`define CHUNK_STREAM_SLOT_TABLE_MACROS_SVH

// same-cycle implication
`define CST_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/cst_pkg.sv -----
package cst_pkg;

    localparam int KEY_W  = 17;
    localparam int SIZE_W = 31;
    localparam int OP_W   = 2;
    localparam int STAT_W = 3;

    localparam logic [SIZE_W-1:0] RESET_CHUNK_SIZE = 31'd128;

    typedef enum logic [OP_W-1:0] {
        OP_GET      = 2'd0,
        OP_SET_ALL  = 2'd1,
        OP_RELEASE  = 2'd2,
        OP_CLEAR    = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_FOUND = 3'd0,
        ST_ALLOC = 3'd1,
        ST_FULL  = 3'd2,
        ST_DONE  = 3'd3,
        ST_RANGE = 3'd4
    } t_status;

    typedef struct packed {
        logic              active;
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] size;
    } t_entry;

endpackage

// ----- src/cst_ram.sv -----
module cst_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  cst_pkg::t_entry       i_wdata,
    input  logic                  i_re,
    input  logic [AW-1:0]         i_raddr,
    output cst_pkg::t_entry       o_rdata
);

    cst_pkg::t_entry r_mem [DEPTH];
    cst_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/cst_seq.sv -----
`include "chunk_stream_slot_table_macros.svh"

module cst_seq #(
    parameter int MAX_STREAMS = 64,
    parameter int SW = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1,
    parameter int UW = $clog2(MAX_STREAMS + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [cst_pkg::OP_W-1:0]    i_operation,
    input  logic [cst_pkg::KEY_W-1:0]   i_stream_id,
    input  logic [cst_pkg::SIZE_W-1:0]  i_new_chunk_size,
    input  logic [SW-1:0]               i_slot_index,
    input  logic [cst_pkg::SIZE_W-1:0]  i_reset_chunk_size,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output logic [cst_pkg::STAT_W-1:0]  o_res_status,
    output logic [SW-1:0]               o_res_slot,
    output logic [cst_pkg::SIZE_W-1:0]  o_res_size,
    output logic                        o_mem_we,
    output logic [SW-1:0]               o_mem_waddr,
    output cst_pkg::t_entry             o_mem_wdata,
    output logic                        o_mem_re,
    output logic [SW-1:0]               o_mem_raddr,
    input  cst_pkg::t_entry             i_mem_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GET,
        S_SET,
        S_DONE
    } t_state;

    localparam logic [UW-1:0] MAX_USED = UW'(MAX_STREAMS);

    t_state                       r_state;
    logic [UW-1:0]                r_used;
    logic [cst_pkg::SIZE_W-1:0]   r_cur;
    logic [cst_pkg::KEY_W-1:0]    r_id;
    logic [UW-1:0]                r_cnt;
    logic                         r_pend;
    logic [SW-1:0]                r_pidx;
    logic                         r_free_vld;
    logic [SW-1:0]                r_free;
    cst_pkg::t_status             r_res_status;
    logic [SW-1:0]                r_res_slot;
    logic [cst_pkg::SIZE_W-1:0]   r_res_size;

    logic w_accept;
    logic w_in_range;
    logic w_hit;
    logic w_issue;
    logic w_drain;
    logic w_room;

    assign o_ready     = (r_state == S_IDLE);
    assign w_accept    = i_valid && o_ready;
    assign w_in_range  = UW'(i_slot_index) < r_used;
    assign w_hit       = r_pend && i_mem_rdata.active && (i_mem_rdata.key == r_id);
    assign w_issue     = ((r_state == S_GET) || (r_state == S_SET)) && (r_cnt < r_used);
    assign w_drain     = !r_pend && (r_cnt >= r_used);
    assign w_room      = r_used < MAX_USED;

    assign o_mem_re    = w_issue;
    assign o_mem_raddr = r_cnt[SW-1:0];

    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_waddr = i_slot_index;
        o_mem_wdata = '{active: 1'b0, key: '0, size: r_cur};
        unique case (r_state)
            S_IDLE: begin
                o_mem_we = w_accept && (cst_pkg::t_op'(i_operation) == cst_pkg::OP_RELEASE)
                           && w_in_range;
            end
            S_GET: begin
                o_mem_we    = w_drain && (r_free_vld || w_room);
                o_mem_waddr = r_free_vld ? r_free : r_used[SW-1:0];
                o_mem_wdata = '{active: 1'b1, key: r_id, size: r_cur};
            end
            S_SET: begin
                o_mem_we    = r_pend && i_mem_rdata.active;
                o_mem_waddr = r_pidx;
                o_mem_wdata = '{active: 1'b1, key: i_mem_rdata.key, size: r_cur};
            end
            default: begin
                o_mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_used     <= '0;
            r_cur      <= cst_pkg::RESET_CHUNK_SIZE;
            r_pend     <= 1'b0;
            r_free_vld <= 1'b0;
            r_cnt      <= '0;
        end else begin
            r_pend <= w_issue;
            r_pidx <= r_cnt[SW-1:0];
            if (w_issue) begin
                r_cnt <= r_cnt + UW'(1);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_id       <= i_stream_id;
                        r_cnt      <= '0;
                        r_free_vld <= 1'b0;
                        unique case (cst_pkg::t_op'(i_operation))
                            cst_pkg::OP_GET: begin
                                r_state <= S_GET;
                            end
                            cst_pkg::OP_SET_ALL: begin
                                r_cur   <= i_new_chunk_size;
                                r_state <= S_SET;
                            end
                            cst_pkg::OP_RELEASE: begin
                                r_res_slot <= '0;
                                if (w_in_range) begin
                                    r_res_status <= cst_pkg::ST_DONE;
                                    r_res_size   <= r_cur;
                                end else begin
                                    r_res_status <= cst_pkg::ST_RANGE;
                                    r_res_size   <= '0;
                                end
                                r_state <= S_DONE;
                            end
                            cst_pkg::OP_CLEAR: begin
                                r_used       <= '0;
                                r_cur        <= i_reset_chunk_size;
                                r_res_status <= cst_pkg::ST_DONE;
                                r_res_slot   <= '0;
                                r_res_size   <= i_reset_chunk_size;
                                r_state      <= S_DONE;
                            end
                        endcase
                    end
                end
                S_GET: begin
                    if (w_hit) begin
                        r_res_status <= cst_pkg::ST_FOUND;
                        r_res_slot   <= r_pidx;
                        r_res_size   <= i_mem_rdata.size;
                        r_state      <= S_DONE;
                    end else if (r_pend) begin
                        if (!i_mem_rdata.active && !r_free_vld) begin
                            r_free_vld <= 1'b1;
                            r_free     <= r_pidx;
                        end
                    end else if (w_drain) begin
                        if (r_free_vld) begin
                            r_res_status <= cst_pkg::ST_ALLOC;
                            r_res_slot   <= r_free;
                            r_res_size   <= r_cur;
                        end else if (w_room) begin
                            r_res_status <= cst_pkg::ST_ALLOC;
                            r_res_slot   <= r_used[SW-1:0];
                            r_res_size   <= r_cur;
                            r_used       <= r_used + UW'(1);
                        end else begin
                            r_res_status <= cst_pkg::ST_FULL;
                            r_res_slot   <= '0;
                            r_res_size   <= '0;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_SET: begin
                    if (w_drain) begin
                        r_res_status <= cst_pkg::ST_DONE;
                        r_res_slot   <= '0;
                        r_res_size   <= r_cur;
                        r_state      <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res_valid  = (r_state == S_DONE);
    assign o_res_status = r_res_status;
    assign o_res_slot   = r_res_slot;
    assign o_res_size   = r_res_size;

    `CST_ASSERT_IMPL(a_used_bound, i_clk, i_rst_n, 1'b1, r_used <= MAX_USED, "slot count above maximum")
    `CST_ASSERT_IMPL(a_scan_bound, i_clk, i_rst_n, (r_state == S_GET) || (r_state == S_SET), r_cnt <= r_used, "scan pointer past used slots")
    `CST_ASSERT_IMPL(a_no_rw_clash, i_clk, i_rst_n, o_mem_we && o_mem_re, o_mem_waddr != o_mem_raddr, "read and write hit one entry")
    `CST_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_accept, r_state != S_IDLE, "accepted transfer left no work")

endmodule

// ----- src/chunk_stream_slot_table.sv -----
// Channel | Direction | Signals
// ------- | --------- | -----------------------------------------------------------
// input   | in        | i_valid/o_ready: i_operation, i_stream_id, i_new_chunk_size,
//         |           | i_slot_index
// result  | out       | o_valid/i_ready: o_status, o_slot, o_slot_chunk_size
// config  | in        | i_cfg_valid/o_cfg_ready: i_cfg_data (reset chunk size)
//
// Release and clear pass from transfer to result through the S_DONE state and the
// output register. Get and set-all sweep the used slots through the slot RAM, one
// read per cycle; a get hit at slot k ends the sweep there. Reset is synchronous,
// active low, and empties the table at once (slot count to zero). A stalled result
// holds in the output register; one more transfer is taken meanwhile and waits
// finished until it drains.
module chunk_stream_slot_table #(
    parameter int MAX_STREAMS = 64
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    output logic                                      o_ready,
    input  logic [cst_pkg::OP_W-1:0]                  i_operation,
    input  logic [cst_pkg::KEY_W-1:0]                 i_stream_id,
    input  logic [cst_pkg::SIZE_W-1:0]                i_new_chunk_size,
    input  logic [((MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1)-1:0] i_slot_index,
    output logic                                      o_valid,
    input  logic                                      i_ready,
    output logic [cst_pkg::STAT_W-1:0]                o_status,
    output logic [((MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1)-1:0] o_slot,
    output logic [cst_pkg::SIZE_W-1:0]                o_slot_chunk_size,
    input  logic                                      i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  logic [cst_pkg::SIZE_W-1:0]                i_cfg_data
);

    localparam int SW = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
    localparam int UW = $clog2(MAX_STREAMS + 1);

    logic [cst_pkg::SIZE_W-1:0]  r_reset_chunk_size;
    logic                        r_o_valid;
    logic [cst_pkg::STAT_W-1:0]  r_o_status;
    logic [SW-1:0]               r_o_slot;
    logic [cst_pkg::SIZE_W-1:0]  r_o_size;

    logic                        w_res_valid;
    logic                        w_res_ready;
    logic [cst_pkg::STAT_W-1:0]  w_res_status;
    logic [SW-1:0]               w_res_slot;
    logic [cst_pkg::SIZE_W-1:0]  w_res_size;

    logic                        w_mem_we;
    logic [SW-1:0]               w_mem_waddr;
    cst_pkg::t_entry             w_mem_wdata;
    logic                        w_mem_re;
    logic [SW-1:0]               w_mem_raddr;
    cst_pkg::t_entry             w_mem_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reset_chunk_size <= cst_pkg::RESET_CHUNK_SIZE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_reset_chunk_size <= i_cfg_data;
        end
    end

    assign w_res_ready = !r_o_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_o_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_o_status <= w_res_status;
            r_o_slot   <= w_res_slot;
            r_o_size   <= w_res_size;
        end
    end

    assign o_valid           = r_o_valid;
    assign o_status          = r_o_status;
    assign o_slot            = r_o_slot;
    assign o_slot_chunk_size = r_o_size;

    cst_seq #(
        .MAX_STREAMS (MAX_STREAMS),
        .SW          (SW),
        .UW          (UW)
    ) u_seq (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_operation        (i_operation),
        .i_stream_id        (i_stream_id),
        .i_new_chunk_size   (i_new_chunk_size),
        .i_slot_index       (i_slot_index),
        .i_reset_chunk_size (r_reset_chunk_size),
        .o_res_valid        (w_res_valid),
        .i_res_ready        (w_res_ready),
        .o_res_status       (w_res_status),
        .o_res_slot         (w_res_slot),
        .o_res_size         (w_res_size),
        .o_mem_we           (w_mem_we),
        .o_mem_waddr        (w_mem_waddr),
        .o_mem_wdata        (w_mem_wdata),
        .o_mem_re           (w_mem_re),
        .o_mem_raddr        (w_mem_raddr),
        .i_mem_rdata        (w_mem_rdata)
    );

    cst_ram #(
        .DEPTH (MAX_STREAMS),
        .AW    (SW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int MAX_STREAMS  = 64;
    localparam int SLOT_W       = $clog2(MAX_STREAMS);
    localparam int NUM_PHASES   = 5;
    localparam int PHASE_ITEMS  = 270;
    localparam int TAIL_CYCLES  = 100;
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_AFTER   = 200;
    localparam int HOLD_CYCLES  = 300;

    typedef struct {
        cst_pkg::t_op                op;
        logic [cst_pkg::KEY_W-1:0]   stream_id;
        logic [cst_pkg::SIZE_W-1:0]  new_size;
        logic [SLOT_W-1:0]           slot_idx;
    } t_slot_req;

    typedef struct {
        cst_pkg::t_status            status;
        logic [SLOT_W-1:0]           slot;
        logic [cst_pkg::SIZE_W-1:0]  slot_size;
    } t_slot_rsp;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        o_ready;
    logic [cst_pkg::OP_W-1:0]    i_operation = '0;
    logic [cst_pkg::KEY_W-1:0]   i_stream_id = '0;
    logic [cst_pkg::SIZE_W-1:0]  i_new_chunk_size = '0;
    logic [SLOT_W-1:0]           i_slot_index = '0;
    logic                        o_valid;
    logic                        i_ready = 1'b0;
    logic [cst_pkg::STAT_W-1:0]  o_status;
    logic [SLOT_W-1:0]           o_slot;
    logic [cst_pkg::SIZE_W-1:0]  o_slot_chunk_size;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [cst_pkg::SIZE_W-1:0]  i_cfg_data = '0;

    chunk_stream_slot_table #(
        .MAX_STREAMS(MAX_STREAMS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_operation      (i_operation),
        .i_stream_id      (i_stream_id),
        .i_new_chunk_size (i_new_chunk_size),
        .i_slot_index     (i_slot_index),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_slot           (o_slot),
        .o_slot_chunk_size(o_slot_chunk_size),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    // shadow of the slot table
    logic [cst_pkg::KEY_W-1:0]  shadow_key [MAX_STREAMS];
    bit                         shadow_active [MAX_STREAMS];
    logic [cst_pkg::SIZE_W-1:0] shadow_size [MAX_STREAMS];
    int                         shadow_used = 0;
    logic [cst_pkg::SIZE_W-1:0] shadow_cur_size = cst_pkg::RESET_CHUNK_SIZE;
    logic [cst_pkg::SIZE_W-1:0] cfg_reset_size = cst_pkg::RESET_CHUNK_SIZE;

    t_slot_req ops_to_send [$];
    t_slot_rsp results_due [$];
    t_slot_req in_flight;
    t_slot_rsp want;

    int n_sent = 0;
    int n_results = 0;
    int n_fail = 0;
    int n_status [5] = '{0, 0, 0, 0, 0};
    int send_idle_pct = 25;
    int recv_idle_pct = 25;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_left = 0;
    bit hold_done = 0;

    function automatic t_slot_rsp slot_table_apply(input t_slot_req r);
        t_slot_rsp rsp;
        int i;
        int hit;
        rsp.status = cst_pkg::ST_DONE;
        rsp.slot = '0;
        rsp.slot_size = '0;
        hit = -1;
        case (r.op)
            cst_pkg::OP_GET: begin
                for (i = 0; i < shadow_used; i++)
                    if (hit < 0 && shadow_active[i] && shadow_key[i] == r.stream_id) hit = i;
                if (hit >= 0) begin
                    rsp.status = cst_pkg::ST_FOUND;
                    rsp.slot = SLOT_W'(hit);
                    rsp.slot_size = shadow_size[hit];
                end else begin
                    for (i = 0; i < shadow_used; i++)
                        if (hit < 0 && !shadow_active[i]) hit = i;
                    if (hit < 0 && shadow_used < MAX_STREAMS) begin
                        hit = shadow_used;
                        shadow_used++;
                    end
                    if (hit < 0) begin
                        rsp.status = cst_pkg::ST_FULL;
                    end else begin
                        shadow_key[hit] = r.stream_id;
                        shadow_active[hit] = 1'b1;
                        shadow_size[hit] = shadow_cur_size;
                        rsp.status = cst_pkg::ST_ALLOC;
                        rsp.slot = SLOT_W'(hit);
                        rsp.slot_size = shadow_cur_size;
                    end
                end
            end
            cst_pkg::OP_SET_ALL: begin
                shadow_cur_size = r.new_size;
                for (i = 0; i < shadow_used; i++)
                    if (shadow_active[i]) shadow_size[i] = r.new_size;
                rsp.slot_size = shadow_cur_size;
            end
            cst_pkg::OP_RELEASE: begin
                if (int'(r.slot_idx) >= shadow_used) begin
                    rsp.status = cst_pkg::ST_RANGE;
                end else begin
                    shadow_active[r.slot_idx] = 1'b0;
                    shadow_key[r.slot_idx] = '0;
                    shadow_size[r.slot_idx] = shadow_cur_size;
                    rsp.slot_size = shadow_cur_size;
                end
            end
            default: begin
                for (i = 0; i < MAX_STREAMS; i++) shadow_active[i] = 1'b0;
                shadow_used = 0;
                shadow_cur_size = cfg_reset_size;
                rsp.slot_size = shadow_cur_size;
            end
        endcase
        return rsp;
    endfunction

    function automatic t_slot_req mk_req(input cst_pkg::t_op op,
                                         input logic [cst_pkg::KEY_W-1:0] id,
                                         input logic [cst_pkg::SIZE_W-1:0] sz,
                                         input logic [SLOT_W-1:0] idx);
        t_slot_req r;
        r.op = op;
        r.stream_id = id;
        r.new_size = sz;
        r.slot_idx = idx;
        return r;
    endfunction

    function automatic t_slot_req rand_req();
        t_slot_req r;
        r.op = cst_pkg::t_op'($urandom_range(0, 3));
        r.stream_id = cst_pkg::KEY_W'($urandom);
        r.new_size = cst_pkg::SIZE_W'($urandom);
        r.slot_idx = SLOT_W'($urandom);
        return r;
    endfunction

    function automatic logic [cst_pkg::SIZE_W-1:0] pick_size();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        if (roll < 5) return cst_pkg::SIZE_W'($urandom_range(1, 4096));
        return cst_pkg::SIZE_W'($urandom);
    endfunction

    // a burst of traffic between clears; a few bursts use enough distinct ids to fill the table
    task automatic queue_episode(input bit lead_clear, inout int added);
        logic [cst_pkg::KEY_W-1:0] pool [$];
        t_slot_req r;
        int kind;
        int npool;
        int len;
        int k;
        int roll;
        int base;
        kind = $urandom_range(0, 9);
        if (kind < 5) npool = $urandom_range(1, 12);
        else if (kind < 8) npool = $urandom_range(40, 80);
        else npool = $urandom_range(66, 72);
        base = $urandom_range(0, (1 << cst_pkg::KEY_W) - 100);
        for (k = 0; k < npool; k++) begin
            if (kind >= 8) pool.push_back(cst_pkg::KEY_W'(base + k));
            else if ($urandom_range(0, 1)) pool.push_back(cst_pkg::KEY_W'($urandom_range(0, 63)));
            else pool.push_back(cst_pkg::KEY_W'($urandom));
        end
        if (lead_clear) begin
            r = rand_req();
            r.op = cst_pkg::OP_CLEAR;
            ops_to_send.push_back(r);
            added++;
        end
        if (kind >= 8) begin
            for (k = 0; k < npool; k++) begin
                r = rand_req();
                r.op = cst_pkg::OP_GET;
                r.stream_id = pool[k];
                ops_to_send.push_back(r);
                added++;
            end
        end
        len = $urandom_range(20, 80);
        for (k = 0; k < len; k++) begin
            r = rand_req();
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
                r.op = cst_pkg::OP_GET;
                r.stream_id = pool[$urandom_range(0, npool - 1)];
            end else if (roll < 80) begin
                r.op = cst_pkg::OP_RELEASE;
                if (roll < 75) r.slot_idx = SLOT_W'($urandom_range(0, (npool > 63) ? 63 : npool));
            end else if (roll < 90) begin
                r.op = cst_pkg::OP_SET_ALL;
                r.new_size = pick_size();
            end
            ops_to_send.push_back(r);
            added++;
        end
    endtask

    task automatic wait_idle();
        while (ops_to_send.size() != 0 || i_valid || results_due.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reset_size(input logic [cst_pkg::SIZE_W-1:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        cfg_reset_size = v;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                results_due.push_back(slot_table_apply(in_flight));
                n_sent++;
            end
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (ops_to_send.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (hold_left == 0 && $urandom_range(0, 99) < send_idle_pct) begin
                    send_gap = $urandom_range(0, 11);
                    i_valid <= 1'b0;
                end else begin
                    in_flight = ops_to_send.pop_front();
                    i_operation <= in_flight.op;
                    i_stream_id <= in_flight.stream_id;
                    i_new_chunk_size <= in_flight.new_size;
                    i_slot_index <= in_flight.slot_idx;
                    i_valid <= 1'b1;
                end
            end
        end
    end

    // monitor and result-side flow control
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                n_results++;
                if (results_due.size() == 0) begin
                    $error("unexpected result: status %0d slot %0d slot_chunk_size %0d",
                           o_status, o_slot, o_slot_chunk_size);
                    n_fail++;
                end else begin
                    want = results_due.pop_front();
                    n_status[want.status]++;
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, o_status);
                        n_fail++;
                    end
                    if (o_slot !== want.slot) begin
                        $error("slot: expected %0d, actual %0d", want.slot, o_slot);
                        n_fail++;
                    end
                    if (o_slot_chunk_size !== want.slot_size) begin
                        $error("slot_chunk_size: expected %0d, actual %0d",
                               want.slot_size, o_slot_chunk_size);
                        n_fail++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (!hold_done && n_results >= HOLD_AFTER && ops_to_send.size() > 4) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                i_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                i_ready <= 1'b0;
            end else if ($urandom_range(0, 99) < recv_idle_pct) begin
                recv_gap = $urandom_range(0, 11);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        logic [cst_pkg::SIZE_W-1:0] cfg_plan [NUM_PHASES];
        int ph;
        int added;
        cfg_plan[0] = '1;
        cfg_plan[1] = cst_pkg::SIZE_W'(1);
        cfg_plan[2] = cst_pkg::SIZE_W'($urandom_range(2, 32'h7FFF_FFFE));
        cfg_plan[3] = cst_pkg::SIZE_W'(4096);
        cfg_plan[4] = cst_pkg::RESET_CHUNK_SIZE;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset size, key extremes, zero and max sizes, reuse, range errors
        ops_to_send.push_back(mk_req(cst_pkg::OP_GET,     cst_pkg::KEY_W'(0),     '0, '0));
        ops_to_send.push_back(mk_req(cst_pkg::OP_GET,     cst_pkg::KEY_W'(0),     '1, '1));
        ops_to_send.push_back(mk_req(cst_pkg::OP_GET,     '1,                     '0, '0));
        ops_to_send.push_back(mk_req(cst_pkg::OP_GET,     cst_pkg::KEY_W'(65599), '0, '0));
        ops_to_send.push_back(mk_req(cst_pkg::OP_SET_ALL, '0,                     '0, '0));
        ops_to_send.push_back(mk_req(cst_pkg::OP_GET,     cst_pkg::KEY_W'(7),     '0, '0));
        ops_to_send.push_back(mk_req(cst_pkg::OP_GET,     '1,                     '0, '0));
        ops_to_send.push_back(mk_req(cst_pkg::OP_SET_ALL, '1,                     '1, '1));
        ops_to_send.push_back(mk_req(cst_pkg::OP_RELEASE, '0, '0, SLOT_W'(1)));
        ops_to_send.push_back(mk_req(cst_pkg::OP_RELEASE, '0, '0, SLOT_W'(1)));
        ops_to_send.push_back(mk_req(cst_pkg::OP_GET,     cst_pkg::KEY_W'(65599), '0, '0));
        ops_to_send.push_back(mk_req(cst_pkg::OP_GET,     '1,                     '0, '0));
        ops_to_send.push_back(mk_req(cst_pkg::OP_RELEASE, '0, '0, SLOT_W'(4)));
        ops_to_send.push_back(mk_req(cst_pkg::OP_RELEASE, '1,                     '1, '1));
        ops_to_send.push_back(mk_req(cst_pkg::OP_CLEAR,   '1,                     '1, '1));
        ops_to_send.push_back(mk_req(cst_pkg::OP_RELEASE, '0,                     '0, '0));
        ops_to_send.push_back(mk_req(cst_pkg::OP_GET,     cst_pkg::KEY_W'(2),     '0, '0));
        ops_to_send.push_back(mk_req(cst_pkg::OP_RELEASE, '0, '0, SLOT_W'(1)));
        ops_to_send.push_back(mk_req(cst_pkg::OP_CLEAR,   '0,                     '0, '0));
        wait_idle();

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin send_idle_pct = 30; recv_idle_pct = 30; end
                1: begin send_idle_pct = 10; recv_idle_pct = 50; end
                2: begin send_idle_pct = 50; recv_idle_pct = 10; end
                3: begin send_idle_pct = 0;  recv_idle_pct = 20; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            write_reset_size(cfg_plan[ph]);
            // first burst runs before any clear, so the new size must not show yet
            added = 0;
            while (added < PHASE_ITEMS) queue_episode(added > 0, added);
            wait_idle();
        end

        if (results_due.size() != 0) begin
            $error("%0d expected results never arrived", results_due.size());
            n_fail++;
        end
        $display("Covered %0d requests and %0d checked results over %0d reset chunk sizes.",
                 n_sent, n_results, NUM_PHASES + 1);
        $display("Outcomes: %0d found, %0d allocated, %0d full, %0d done, %0d out of range.",
                 n_status[cst_pkg::ST_FOUND], n_status[cst_pkg::ST_ALLOC],
                 n_status[cst_pkg::ST_FULL], n_status[cst_pkg::ST_DONE],
                 n_status[cst_pkg::ST_RANGE]);
        if (n_fail == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
